@@ rtl/thkl_pkg.sv @@
// shared types, coefficient tables and elaboration-time table builders
package thkl_pkg;

  // fixed-point format
  localparam int FRAC_BITS          = 32;
  localparam int TEMP_OUT_FRAC_BITS = 4;
  localparam int EXP_TABLE_DEPTH    = 2048;
  localparam int EXP_AW             = $clog2(EXP_TABLE_DEPTH);
  localparam int EXP_W              = FRAC_BITS - 2;
  localparam int VAL_W              = 64;
  localparam int HALF_W             = VAL_W / 2;
  localparam int PROD_W             = 2 * VAL_W;
  localparam int THERMO_W           = 14;
  localparam int JUNCT_W            = 12;
  localparam int DIFF_W             = 17;
  localparam int TEMP_W             = 17;
  localparam int QUEUE_DEPTH        = 2;

  localparam longint SAT_LIM = 64'sd1 <<< 61;

  // segment codes
  localparam logic [1:0] SEG_NEG  = 2'd0;
  localparam logic [1:0] SEG_LOW  = 2'd1;
  localparam logic [1:0] SEG_HIGH = 2'd2;
  localparam logic [1:0] SEG_OOR  = 2'd3;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic signed [THERMO_W-1:0] thermo_raw;
    logic signed [JUNCT_W-1:0]  junction_raw;
  } in_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] corrected_temp;
    logic [1:0]               segment_used;
    logic                     out_of_range;
  } out_t;

  // classified word handed from front to back
  typedef struct packed {
    logic signed [DIFF_W-1:0]  diff;
    logic signed [JUNCT_W-1:0] jr;
    logic                      cj_neg;
  } job_t;

  typedef enum logic [2:0] {
    POLY_VTC, POLY_CJP, POLY_CJN, POLY_INV0, POLY_INV1, POLY_INV2
  } poly_t;

  // quotient truncated toward zero, by shift and subtract; den is positive
  function automatic longint const_div_trunc(longint num, longint den);
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] r;
    mag = (num < 0) ? 64'(-num) : 64'(num);
    q   = '0;
    r   = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], mag[i]};
      if (r >= 64'(den)) begin
        r    = r - 64'(den);
        q[i] = 1'b1;
      end
    end
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // round(m * 10^e * 2^b), saturated
  function automatic longint to_fixed(longint m, int e, int b);
    logic [63:0] x;
    int ee;
    int bb;
    int n;
    x  = (m < 0) ? 64'(-m) : 64'(m);
    ee = e;
    bb = b;
    if (x == 64'd0) return 64'sd0;
    while (ee < 0) begin
      while (x < (64'd1 << 59)) begin
        x  = x << 1;
        bb = bb - 1;
      end
      x  = 64'(const_div_trunc(longint'(x), 64'sd10));
      ee = ee + 1;
    end
    while (ee > 0) begin
      while (x >= (64'd1 << 59)) begin
        x  = x >> 1;
        bb = bb + 1;
      end
      x  = x * 64'd10;
      ee = ee - 1;
    end
    if (bb >= 0) begin
      if (bb >= 62 || x > (64'(SAT_LIM) >> bb)) x = 64'(SAT_LIM);
      else x = x << bb;
    end else begin
      n = -bb;
      if (n >= 64) x = 64'd0;
      else x = (x >> n) + ((x >> (n - 1)) & 64'd1);
      if (x > 64'(SAT_LIM)) x = 64'(SAT_LIM);
    end
    return (m < 0) ? -longint'(x) : longint'(x);
  endfunction

  // round(a*b / 2^sh) half away from zero, saturated
  function automatic longint const_mul_shift(longint a, longint b, int sh);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] p;
    longint       r;
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    p  = {64'd0, ua} * {64'd0, ub};
    p  = p + (128'd1 << (sh - 1));
    p  = p >> sh;
    if (p > 128'(SAT_LIM)) p = 128'(SAT_LIM);
    r = longint'(p[63:0]);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // floor((x + 2^(n-1)) / 2^n)
  function automatic longint const_rsh_round(longint x, int n);
    if (n == 0) return x;
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // cold-junction exponential term, one entry per non-negative count
  typedef logic [EXP_W-1:0] exp_tbl_t [EXP_TABLE_DEPTH];

  function automatic exp_tbl_t build_exp_tbl();
    exp_tbl_t tbl;
    longint   a0;
    longint   a1;
    longint   a2;
    longint   diff;
    longint   sq;
    longint   y;
    longint   term;
    longint   sum;
    a0 = to_fixed(64'sd1185976, -7, 58);
    a1 = to_fixed(-64'sd1183432, -10, 58);
    a2 = to_fixed(64'sd1269686, -4, 44);
    for (int j = 0; j < EXP_TABLE_DEPTH; j++) begin
      diff = longint'(j) * (64'sd1 <<< 40) - a2;
      sq   = const_mul_shift(diff, diff, 44);
      y    = const_rsh_round(const_mul_shift(sq, a1, 44), 3);
      term = 64'sd1 <<< 58;
      sum  = term;
      for (int n = 1; n <= 14; n++) begin
        term = const_div_trunc(const_mul_shift(term, y, 58), longint'(n));
        sum  = sum + term;
      end
      for (int k = 0; k < 3; k++) sum = const_mul_shift(sum, sum, 58);
      tbl[j] = EXP_W'(const_rsh_round(const_mul_shift(sum, a0, 58), 58 - FRAC_BITS));
    end
    return tbl;
  endfunction

  localparam exp_tbl_t EXP_TBL = build_exp_tbl();

  // segment thresholds in millivolts
  localparam val_t THR1 = val_t'(to_fixed(64'sd20644, -3, FRAC_BITS));
  localparam val_t THR2 = val_t'(to_fixed(64'sd54886, -3, FRAC_BITS));

  // all polynomial coefficients, lowest order first within each polynomial
  localparam int COEF_N  = 49;
  localparam int COEF_IW = $clog2(COEF_N);
  typedef val_t coef_tbl_t [COEF_N];

  localparam coef_tbl_t COEF_TBL = '{
    // mV per degree, applied to the count difference
    64'sd0,
    to_fixed(64'sd41276, -6, FRAC_BITS),
    // cold junction, positive branch, variable t/128
    to_fixed(-64'sd176004136860, -13, FRAC_BITS),
    to_fixed(64'sd389212049750, -13, FRAC_BITS + 7),
    to_fixed(64'sd185587700320, -16, FRAC_BITS + 14),
    to_fixed(-64'sd994575928740, -19, FRAC_BITS + 21),
    to_fixed(64'sd318409457190, -21, FRAC_BITS + 28),
    to_fixed(-64'sd560728448890, -24, FRAC_BITS + 35),
    to_fixed(64'sd560750590590, -27, FRAC_BITS + 42),
    to_fixed(-64'sd320207200030, -30, FRAC_BITS + 49),
    to_fixed(64'sd971511471520, -34, FRAC_BITS + 56),
    to_fixed(-64'sd121047212750, -37, FRAC_BITS + 63),
    // cold junction, negative branch
    64'sd0,
    to_fixed(64'sd394501280250, -13, FRAC_BITS + 7),
    to_fixed(64'sd236223735980, -16, FRAC_BITS + 14),
    to_fixed(-64'sd328589067840, -18, FRAC_BITS + 21),
    to_fixed(-64'sd499048287770, -20, FRAC_BITS + 28),
    to_fixed(-64'sd675090591730, -22, FRAC_BITS + 35),
    to_fixed(-64'sd574103274280, -24, FRAC_BITS + 42),
    to_fixed(-64'sd310888728940, -26, FRAC_BITS + 49),
    to_fixed(-64'sd104516093650, -28, FRAC_BITS + 56),
    to_fixed(-64'sd198892668780, -31, FRAC_BITS + 63),
    to_fixed(-64'sd163226974860, -34, FRAC_BITS + 70),
    // inverse, negative voltage, variable E/8
    64'sd0,
    to_fixed(64'sd25173462, -6, FRAC_BITS + 3),
    to_fixed(-64'sd11662878, -7, FRAC_BITS + 6),
    to_fixed(-64'sd10833638, -7, FRAC_BITS + 9),
    to_fixed(-64'sd89773540, -8, FRAC_BITS + 12),
    to_fixed(-64'sd37342377, -8, FRAC_BITS + 15),
    to_fixed(-64'sd86632643, -9, FRAC_BITS + 18),
    to_fixed(-64'sd10450598, -9, FRAC_BITS + 21),
    to_fixed(-64'sd51920577, -11, FRAC_BITS + 24),
    // inverse, low range, variable E/32
    64'sd0,
    to_fixed(64'sd2508355, -5, FRAC_BITS + 5),
    to_fixed(64'sd7860106, -8, FRAC_BITS + 10),
    to_fixed(-64'sd2503131, -7, FRAC_BITS + 15),
    to_fixed(64'sd8315270, -8, FRAC_BITS + 20),
    to_fixed(-64'sd1228034, -8, FRAC_BITS + 25),
    to_fixed(64'sd9804036, -10, FRAC_BITS + 30),
    to_fixed(-64'sd4413030, -11, FRAC_BITS + 35),
    to_fixed(64'sd1057734, -12, FRAC_BITS + 40),
    to_fixed(-64'sd1052755, -14, FRAC_BITS + 45),
    // inverse, high range, variable E/64
    to_fixed(-64'sd1318058, -4, FRAC_BITS),
    to_fixed(64'sd4830222, -5, FRAC_BITS + 6),
    to_fixed(-64'sd1646031, -6, FRAC_BITS + 12),
    to_fixed(64'sd5464731, -8, FRAC_BITS + 18),
    to_fixed(-64'sd9650715, -10, FRAC_BITS + 24),
    to_fixed(64'sd8802193, -12, FRAC_BITS + 30),
    to_fixed(-64'sd3110810, -14, FRAC_BITS + 36)
  };

  function automatic int poly_base(poly_t p);
    case (p)
      POLY_VTC:  return 0;
      POLY_CJP:  return 2;
      POLY_CJN:  return 12;
      POLY_INV0: return 23;
      POLY_INV1: return 32;
      POLY_INV2: return 42;
      default:   return 0;
    endcase
  endfunction

  function automatic int poly_len(poly_t p);
    case (p)
      POLY_VTC:  return 2;
      POLY_CJP:  return 10;
      POLY_CJN:  return 11;
      POLY_INV0: return 9;
      POLY_INV1: return 10;
      POLY_INV2: return 7;
      default:   return 2;
    endcase
  endfunction

endpackage

@@ rtl/thkl_ram.sv @@
// generic single-write, single-read ram with registered read data
module thkl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/thkl_front.sv @@
// front end: accepts input words, forms count difference and branch, queues them
module thkl_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  thkl_pkg::in_t  in_data,
  input  logic           fill_done,
  output logic           q_valid,
  output thkl_pkg::job_t q_job,
  input  logic           q_pop
);
  import thkl_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  job_t             job_in;
  logic             push;

  // classify: 4*thermo - junction in sixteenth degrees, junction sign picks branch
  always_comb begin
    job_in.diff   = {{(DIFF_W-THERMO_W-2){in_data.thermo_raw[THERMO_W-1]}},
                     in_data.thermo_raw, 2'b00}
                    - {{(DIFF_W-JUNCT_W){in_data.junction_raw[JUNCT_W-1]}},
                       in_data.junction_raw};
    job_in.jr     = in_data.junction_raw;
    job_in.cj_neg = in_data.junction_raw[JUNCT_W-1];
  end

  assign in_ready = fill_done && (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_job    = mem_r[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

  // queue pointers, wrapping at the power-of-two depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !q_pop) cnt_r <= cnt_r + 1'b1;
      else if (!push && q_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count missed a push");

endmodule

@@ rtl/thkl_back.sv @@
// back end: horner sequencer on a split 64x64 multiplier, segment select, output word
module thkl_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  thkl_pkg::job_t q_job,
  output logic           q_pop,
  output logic           fill_done,
  output logic           out_valid,
  input  logic           out_ready,
  output thkl_pkg::out_t out_data
);
  import thkl_pkg::*;

  localparam int K_W      = 4;
  localparam int FILL_W   = EXP_AW + 1;
  localparam int SH_VTC   = 4;
  localparam int SH_CJ    = 11;
  localparam int SH_INV0  = FRAC_BITS + 3;
  localparam int SH_INV1  = FRAC_BITS + 5;
  localparam int SH_INV2  = FRAC_BITS + 6;
  localparam int OUT_SH   = FRAC_BITS - TEMP_OUT_FRAC_BITS;
  localparam logic [FILL_W-1:0] FILL_END = FILL_W'(EXP_TABLE_DEPTH);
  localparam val_t TEMP_MAX = val_t'(65535);
  localparam val_t TEMP_MIN = -val_t'(65536);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MUL, S_SUM, S_ADD, S_VSUM, S_CLASS, S_FIN
  } state_t;

  state_t             state_r, state_nxt;
  poly_t              poly_r, poly_nxt;
  logic [K_W-1:0]     k_r, k_nxt;
  val_t               acc_r, acc_nxt;
  val_t               x_r, x_nxt;
  val_t               vtc_r, vtc_nxt;
  val_t               v_r, v_nxt;
  logic signed [JUNCT_W-1:0] jr_r, jr_nxt;
  logic               cj_neg_r, cj_neg_nxt;
  logic [1:0]         seg_r, seg_nxt;
  logic [VAL_W-1:0]   pp_r [4];
  logic [VAL_W-1:0]   pp_nxt [4];
  logic               neg_r, neg_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  out_t               out_data_r, out_data_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FILL_W-1:0]  fill_cnt_r, fill_cnt_nxt;

  logic [EXP_W-1:0]   exp_rd;
  logic [VAL_W-1:0]   a_mag, b_mag;
  logic [PROD_W-1:0]  rnd, shifted;
  logic [VAL_W-1:0]   res_mag;
  val_t               res, coef_step, coef_top, step_val;
  logic signed [VAL_W:0] sum_w;
  val_t               t_rnd, t_sh, temp_sat;
  logic [1:0]         seg_c;

  assign fill_done = (fill_cnt_r == FILL_END);

  // exponential term table, loaded by a sweep after reset
  thkl_ram #(
    .WIDTH(EXP_W),
    .DEPTH(EXP_TABLE_DEPTH)
  ) u_exp_ram (
    .clk  (clk),
    .we   (!fill_done),
    .waddr(fill_cnt_r[EXP_AW-1:0]),
    .wdata(EXP_TBL[fill_cnt_r[EXP_AW-1:0]]),
    .raddr(jr_r[EXP_AW-1:0]),
    .rdata(exp_rd)
  );

  // coefficient reads: top of polynomial and next lower order
  assign coef_top  = COEF_TBL[COEF_IW'(poly_base(poly_r) + poly_len(poly_r) - 1)];
  assign coef_step = COEF_TBL[COEF_IW'(poly_base(poly_r) + int'(k_r) - 1)];

  // operand magnitudes for the partial products
  assign a_mag = acc_r[VAL_W-1] ? VAL_W'(-acc_r) : VAL_W'(acc_r);
  assign b_mag = x_r[VAL_W-1] ? VAL_W'(-x_r) : VAL_W'(x_r);

  // round, rescale, saturate product, then add coefficient with saturation
  always_comb begin
    case (poly_r)
      POLY_VTC: begin
        rnd     = prod_r + (PROD_W'(1) << (SH_VTC - 1));
        shifted = rnd >> SH_VTC;
      end
      POLY_CJP, POLY_CJN: begin
        rnd     = prod_r + (PROD_W'(1) << (SH_CJ - 1));
        shifted = rnd >> SH_CJ;
      end
      POLY_INV0: begin
        rnd     = prod_r + (PROD_W'(1) << (SH_INV0 - 1));
        shifted = rnd >> SH_INV0;
      end
      POLY_INV1: begin
        rnd     = prod_r + (PROD_W'(1) << (SH_INV1 - 1));
        shifted = rnd >> SH_INV1;
      end
      POLY_INV2: begin
        rnd     = prod_r + (PROD_W'(1) << (SH_INV2 - 1));
        shifted = rnd >> SH_INV2;
      end
      default: begin
        rnd     = prod_r;
        shifted = prod_r;
      end
    endcase
    res_mag = (shifted > PROD_W'(SAT_LIM)) ? VAL_W'(SAT_LIM) : shifted[VAL_W-1:0];
    res     = neg_r ? -val_t'(res_mag) : val_t'(res_mag);
    sum_w   = {res[VAL_W-1], res} + {coef_step[VAL_W-1], coef_step};
    if (sum_w > (VAL_W+1)'(SAT_LIM)) step_val = val_t'(SAT_LIM);
    else if (sum_w < -(VAL_W+1)'(SAT_LIM)) step_val = -val_t'(SAT_LIM);
    else step_val = sum_w[VAL_W-1:0];
  end

  // segment from total voltage
  always_comb begin
    if (v_r < 0) seg_c = SEG_NEG;
    else if (v_r < THR1) seg_c = SEG_LOW;
    else if (v_r < THR2) seg_c = SEG_HIGH;
    else seg_c = SEG_OOR;
  end

  // final rounding to output fraction bits and field saturation
  always_comb begin
    t_rnd = acc_r + (val_t'(1) <<< (OUT_SH - 1));
    t_sh  = t_rnd >>> OUT_SH;
    if (t_sh > TEMP_MAX) temp_sat = TEMP_MAX;
    else if (t_sh < TEMP_MIN) temp_sat = TEMP_MIN;
    else temp_sat = t_sh;
  end

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    poly_nxt      = poly_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    x_nxt         = x_r;
    vtc_nxt       = vtc_r;
    v_nxt         = v_r;
    jr_nxt        = jr_r;
    cj_neg_nxt    = cj_neg_r;
    seg_nxt       = seg_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    fill_cnt_nxt  = fill_done ? fill_cnt_r : fill_cnt_r + 1'b1;
    q_pop         = 1'b0;
    for (int i = 0; i < 4; i++) pp_nxt[i] = pp_r[i];

    case (state_r)
      S_IDLE: begin
        if (fill_done && q_valid) begin
          q_pop      = 1'b1;
          jr_nxt     = q_job.jr;
          cj_neg_nxt = q_job.cj_neg;
          x_nxt      = {{(VAL_W-DIFF_W){q_job.diff[DIFF_W-1]}}, q_job.diff};
          poly_nxt   = POLY_VTC;
          state_nxt  = S_LOAD;
        end
      end
      S_LOAD: begin
        acc_nxt   = coef_top;
        k_nxt     = K_W'(poly_len(poly_r) - 1);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        pp_nxt[0] = VAL_W'(a_mag[HALF_W-1:0] * b_mag[HALF_W-1:0]);
        pp_nxt[1] = VAL_W'(a_mag[HALF_W-1:0] * b_mag[VAL_W-1:HALF_W]);
        pp_nxt[2] = VAL_W'(a_mag[VAL_W-1:HALF_W] * b_mag[HALF_W-1:0]);
        pp_nxt[3] = VAL_W'(a_mag[VAL_W-1:HALF_W] * b_mag[VAL_W-1:HALF_W]);
        neg_nxt   = acc_r[VAL_W-1] ^ x_r[VAL_W-1];
        state_nxt = S_SUM;
      end
      S_SUM: begin
        prod_nxt  = PROD_W'(pp_r[0])
                  + (PROD_W'(pp_r[1]) << HALF_W)
                  + (PROD_W'(pp_r[2]) << HALF_W)
                  + (PROD_W'(pp_r[3]) << VAL_W);
        state_nxt = S_ADD;
      end
      S_ADD: begin
        acc_nxt = step_val;
        k_nxt   = k_r - 1'b1;
        if (k_r == K_W'(1)) begin
          case (poly_r)
            POLY_VTC: begin
              vtc_nxt   = step_val;
              poly_nxt  = cj_neg_r ? POLY_CJN : POLY_CJP;
              x_nxt     = {{(VAL_W-JUNCT_W){jr_r[JUNCT_W-1]}}, jr_r};
              state_nxt = S_LOAD;
            end
            POLY_CJP, POLY_CJN: state_nxt = S_VSUM;
            default:            state_nxt = S_FIN;
          endcase
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_VSUM: begin
        v_nxt = vtc_r + acc_r
              + (cj_neg_r ? val_t'(0) : val_t'({{(VAL_W-EXP_W){1'b0}}, exp_rd}));
        state_nxt = S_CLASS;
      end
      S_CLASS: begin
        seg_nxt = seg_c;
        x_nxt   = v_r;
        case (seg_c)
          SEG_NEG: begin
            poly_nxt  = POLY_INV0;
            state_nxt = S_LOAD;
          end
          SEG_LOW: begin
            poly_nxt  = POLY_INV1;
            state_nxt = S_LOAD;
          end
          SEG_HIGH: begin
            poly_nxt  = POLY_INV2;
            state_nxt = S_LOAD;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.corrected_temp = (seg_r == SEG_OOR) ? '0 : temp_sat[TEMP_W-1:0];
          out_data_nxt.segment_used   = seg_r;
          out_data_nxt.out_of_range   = (seg_r == SEG_OOR);
          out_valid_nxt               = 1'b1;
          state_nxt                   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state, datapath and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fill_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
    end
    poly_r     <= poly_nxt;
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    x_r        <= x_nxt;
    vtc_r      <= vtc_nxt;
    v_r        <= v_nxt;
    jr_r       <= jr_nxt;
    cj_neg_r   <= cj_neg_nxt;
    seg_r      <= seg_nxt;
    neg_r      <= neg_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
    for (int i = 0; i < 4; i++) pp_r[i] <= pp_nxt[i];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    !fill_done |-> (state_r == S_IDLE))
    else $error("word started before table load finished");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (k_r != '0))
    else $error("horner step with no coefficient left");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.out_of_range == (out_data_r.segment_used == SEG_OOR)))
    else $error("range flag disagrees with segment");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.out_of_range) |-> (out_data_r.corrected_temp == '0))
    else $error("nonzero temperature on out of range word");

endmodule

@@ rtl/thermocouple_k_linearizer_core.sv @@
// type K thermocouple linearizer top level: front queue and horner back end
//
//  channel | ports                           | word
//  input   | in_valid, in_ready, in_data     | thermo_raw, junction_raw
//  result  | out_valid, out_ready, out_data  | corrected_temp, segment_used, out_of_range
//
// in the back end each horner step runs through partial products, product sum, and
// round and add on the shared 64x64 multiplier.
// after reset the 2048-entry exponential table is loaded, with in_ready low meanwhile.
// a two-word queue lets the front accept while the back end works, and the output
// register holds a finished word while the next one is computed.
module thermocouple_k_linearizer_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  thkl_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output thkl_pkg::out_t out_data
);
  import thkl_pkg::*;

  logic fill_done;
  logic q_valid;
  logic q_pop;
  job_t q_job;

  thkl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .fill_done(fill_done),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .q_pop    (q_pop)
  );

  thkl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .q_pop    (q_pop),
    .fill_done(fill_done),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
